// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition never seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/mtep_pkg.sv -----
package mtep_pkg;

  localparam int unsigned VarlenMaxBytes = 4;
  localparam int unsigned VarlenCntW     = 3;
  localparam int unsigned TicksW         = 28;
  localparam int unsigned InDataW        = 8;
  localparam int unsigned OutFieldsW     = 97;
  localparam int unsigned OutDataW       = 104;

  localparam logic [7:0] MetaStatus   = 8'hff;
  localparam logic [3:0] HiNoteOff    = 4'h8;
  localparam logic [3:0] HiNoteOn     = 4'h9;
  localparam logic [3:0] HiKeyPress   = 4'ha;
  localparam logic [3:0] HiControl    = 4'hb;
  localparam logic [3:0] HiProgram    = 4'hc;
  localparam logic [3:0] HiChanPress  = 4'hd;
  localparam logic [3:0] HiSystem     = 4'hf;
  localparam logic [7:0] ModeCtrlLow  = 8'd121;
  localparam logic [7:0] ModeCtrlHigh = 8'd127;

  typedef enum logic [1:0] {
    KindChannel = 2'd0,
    KindMetaHdr = 2'd1,
    KindPayload = 2'd2,
    KindError   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ErrDeltaLong  = 2'd0,
    ErrNoRunning  = 2'd1,
    ErrBadStatus  = 2'd2,
    ErrMetaLenLong = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MsgNoteOff   = 3'd0,
    MsgNoteOn    = 3'd1,
    MsgKeyPress  = 3'd2,
    MsgControl   = 3'd3,
    MsgMode      = 3'd4,
    MsgProgram   = 3'd5,
    MsgChanPress = 3'd6,
    MsgBend      = 3'd7
  } msg_e;

  typedef enum logic [7:0] {
    PhDelta   = 8'b0000_0001,
    PhStatus  = 8'b0000_0010,
    PhData1   = 8'b0000_0100,
    PhData2   = 8'b0000_1000,
    PhMtype   = 8'b0001_0000,
    PhMlen    = 8'b0010_0000,
    PhPayload = 8'b0100_0000,
    PhHalt    = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [TicksW-1:0] delta_ticks;
    msg_e              message_type;
    logic [3:0]        channel;
    logic [7:0]        first_data;
    logic [7:0]        second_data;
    logic [7:0]        meta_kind;
    logic [TicksW-1:0] meta_length;
    logic [7:0]        payload_byte;
    logic              last;
    err_e              error_code;
  } result_t;

  function automatic msg_e type_code(input logic [7:0] status, input logic [7:0] d0);
    msg_e t;
    case (status[7:4])
      HiNoteOff:   t = MsgNoteOff;
      HiNoteOn:    t = MsgNoteOn;
      HiKeyPress:  t = MsgKeyPress;
      HiControl:   t = (d0 >= ModeCtrlLow && d0 <= ModeCtrlHigh) ? MsgMode : MsgControl;
      HiProgram:   t = MsgProgram;
      HiChanPress: t = MsgChanPress;
      default:     t = MsgBend;
    endcase
    return t;
  endfunction

  // fields from the lowest bit up, zero filled to whole bytes
  function automatic logic [OutDataW-1:0] pack_out(input result_t r);
    logic [OutFieldsW-1:0] f;
    f = {r.error_code, r.payload_byte, r.meta_length, r.meta_kind, r.second_data,
         r.first_data, r.channel, r.message_type, r.delta_ticks};
    return {{(OutDataW-OutFieldsW){1'b0}}, f};
  endfunction

endpackage

// ----- rtl/mtep_core.sv -----
module mtep_core #(
  parameter int unsigned VarlenMax = mtep_pkg::VarlenMaxBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            track_start_i,
  output logic                            res_valid_o,
  output mtep_pkg::result_t               res_o
);
  import mtep_pkg::*;

  phase_e                phase_q, phase_d, phase_cur;
  logic [7:0]            rs_q, rs_d, rs_cur;
  logic [TicksW-1:0]     acc_q, acc_d, acc_cur, acc_vl;
  logic [VarlenCntW-1:0] cnt_q, cnt_d, cnt_cur, cnt_vl;
  logic [TicksW-1:0]     delta_q, delta_d;
  logic [7:0]            first_q, first_d;
  logic [7:0]            mkind_q, mkind_d;
  logic [TicksW-1:0]     rem_q, rem_d, rem_dec;
  logic                  vl_more, vl_long, take_first;
  logic                  do_emit, do_fail, do_restart;
  logic [7:0]            emit_d0, emit_d1;
  err_e                  fail_code;

  always_comb begin
    phase_cur = track_start_i ? PhDelta : phase_q;
    rs_cur    = track_start_i ? 8'h00 : rs_q;
    acc_cur   = track_start_i ? '0 : acc_q;
    cnt_cur   = track_start_i ? '0 : cnt_q;

    // one 7-bit group of a variable-length number
    acc_vl  = {acc_cur[TicksW-8:0], data_byte_i[6:0]};
    cnt_vl  = cnt_cur + VarlenCntW'(1);
    vl_more = data_byte_i[7];
    vl_long = data_byte_i[7] && (cnt_vl >= VarlenCntW'(VarlenMax));
    rem_dec = rem_q - TicksW'(1);

    take_first = (phase_cur == PhData1) ||
                 ((phase_cur == PhStatus) && !data_byte_i[7] && rs_cur[7]);

    phase_d = phase_cur;
    rs_d    = rs_cur;
    acc_d   = acc_cur;
    cnt_d   = cnt_cur;
    delta_d = delta_q;
    first_d = first_q;
    mkind_d = mkind_q;
    rem_d   = rem_q;

    do_emit    = 1'b0;
    do_fail    = 1'b0;
    do_restart = 1'b0;
    emit_d0    = data_byte_i;
    emit_d1    = 8'h00;
    fail_code  = ErrDeltaLong;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_cur)
      PhDelta: begin
        acc_d = acc_vl;
        cnt_d = cnt_vl;
        if (vl_long) begin
          do_fail   = 1'b1;
          fail_code = ErrDeltaLong;
        end else if (!vl_more) begin
          delta_d = acc_vl;
          phase_d = PhStatus;
        end
      end
      PhStatus: begin
        if (data_byte_i[7]) begin
          if (data_byte_i == MetaStatus) begin
            rs_d    = 8'h00;
            phase_d = PhMtype;
          end else begin
            rs_d = data_byte_i;
            if (data_byte_i[7:4] == HiSystem) begin
              do_fail   = 1'b1;
              fail_code = ErrBadStatus;
            end else begin
              phase_d = PhData1;
            end
          end
        end else if (!rs_cur[7]) begin
          do_fail   = 1'b1;
          fail_code = ErrNoRunning;
        end
      end
      PhData2: begin
        do_emit = 1'b1;
        emit_d0 = first_q;
        emit_d1 = data_byte_i;
      end
      PhMtype: begin
        mkind_d = data_byte_i;
        acc_d   = '0;
        cnt_d   = '0;
        phase_d = PhMlen;
      end
      PhMlen: begin
        acc_d = acc_vl;
        cnt_d = cnt_vl;
        if (vl_long) begin
          do_fail   = 1'b1;
          fail_code = ErrMetaLenLong;
        end else if (!vl_more) begin
          rem_d             = acc_vl;
          res_valid_o       = 1'b1;
          res_o.kind        = KindMetaHdr;
          res_o.delta_ticks = delta_q;
          res_o.meta_kind   = mkind_q;
          res_o.meta_length = acc_vl;
          if (acc_vl == '0) begin
            res_o.last = 1'b1;
            do_restart = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        rem_d              = rem_dec;
        res_valid_o        = 1'b1;
        res_o.kind         = KindPayload;
        res_o.delta_ticks  = delta_q;
        res_o.meta_kind    = mkind_q;
        res_o.payload_byte = data_byte_i;
        if (rem_dec == '0) begin
          res_o.last = 1'b1;
          do_restart = 1'b1;
        end
      end
      default: ;
    endcase

    // first data byte under a valid running status
    if (take_first) begin
      if (rs_cur[7:4] == HiSystem) begin
        do_fail   = 1'b1;
        fail_code = ErrBadStatus;
      end else if (rs_cur[7:4] == HiProgram || rs_cur[7:4] == HiChanPress) begin
        do_emit = 1'b1;
        emit_d0 = data_byte_i;
        emit_d1 = 8'h00;
      end else begin
        first_d = data_byte_i;
        phase_d = PhData2;
      end
    end

    if (do_emit) begin
      res_valid_o        = 1'b1;
      res_o.kind         = KindChannel;
      res_o.delta_ticks  = delta_q;
      res_o.message_type = type_code(rs_cur, emit_d0);
      res_o.channel      = rs_cur[3:0];
      res_o.first_data   = emit_d0;
      res_o.second_data  = emit_d1;
      res_o.last         = 1'b1;
      do_restart         = 1'b1;
    end

    if (do_restart) begin
      phase_d = PhDelta;
      acc_d   = '0;
      cnt_d   = '0;
    end

    if (do_fail) begin
      res_valid_o      = 1'b1;
      res_o            = '0;
      res_o.kind       = KindError;
      res_o.last       = 1'b1;
      res_o.error_code = fail_code;
      phase_d          = PhHalt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDelta;
      rs_q    <= 8'h00;
      acc_q   <= '0;
      cnt_q   <= '0;
      delta_q <= '0;
      first_q <= 8'h00;
      mkind_q <= 8'h00;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      delta_q <= delta_d;
      first_q <= first_d;
      mkind_q <= mkind_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// midi track event parser
// slave stream: one word per track body byte; tdata carries the byte, tuser
//   the track start flag, which clears running status and any error halt
//   before that byte is parsed
// master stream: at most one word per input byte; tuser gives the kind
//   (channel message, meta header, meta payload byte, error), tlast marks the
//   final word of an event, tdata carries the other result fields
// a byte is registered in the input register, parsed from there, and its
//   result word is registered in the output register
// throughput: one byte per cycle while the master side does not stall, set by
//   the combinational parser step between the input and output registers
// a stalled master side holds the output word; an empty input register
//   still takes one more byte, then tready drops until the output word leaves
// reset clears both registers' valid flags and returns the parser to
//   expecting a delta time with no running status
// after an error the parser drops all bytes until one arrives with track
//   start set
module midi_track_event_parser #(
  parameter int unsigned VarlenMax = mtep_pkg::VarlenMaxBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mtep_pkg::InDataW-1:0]   s_axis_tdata,  // data_byte
  input  logic                           s_axis_tuser,  // track_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // delta ticks, message_type, channel, first_data, second_data, meta_kind,
  // meta_length, payload_byte, error_code, zero fill
  output logic [mtep_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // kind
  output logic                           m_axis_tlast   // last
);
  import mtep_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_start_q;

  // output register
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  logic             step;
  logic             res_valid;
  result_t          res;

  // parse the held byte whenever the output register can take its result
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  assign in_valid_d  = s_axis_tvalid ? 1'b1 : (in_valid_q && !step);
  assign out_valid_d = step ? res_valid : (out_valid_q && !m_axis_tready);

  mtep_core #(
    .VarlenMax (VarlenMax)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (in_byte_q),
    .track_start_i (in_start_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= in_valid_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pack_out(out_q);
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

// ----- rtl/mtep_checker.sv -----
`include "assert_macros.svh"

module mtep_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [mtep_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [mtep_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic [1:0]                     m_axis_tuser,
  input  logic                           m_axis_tlast
);
  import mtep_pkg::*;

  logic out_stall;
  logic kind_ends_event;
  logic hdr_or_pay_nonzero;

  assign out_stall       = m_axis_tvalid && !m_axis_tready;
  assign kind_ends_event = (m_axis_tuser == KindChannel) || (m_axis_tuser == KindError);
  // error words carry only the error code
  assign hdr_or_pay_nonzero = (m_axis_tdata[94:0] != '0);

  // a stalled output word holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

  // input side only backs up while an output word waits
  `ASSERT_PROP(a_ready_low_needs_stall, clk_i, rst_ni, !s_axis_tready |-> out_stall)

  // channel messages and errors always end an event
  `ASSERT_PROP(a_last_on_single, clk_i, rst_ni,
    (m_axis_tvalid && kind_ends_event) |-> m_axis_tlast)

  // error words hold nothing but the code
  `ASSERT_NEVER(a_error_clean, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == KindError) && hdr_or_pay_nonzero)

  // the zero fill above the fields stays clear
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tdata[OutDataW-1:OutFieldsW] != '0))

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
